[hdl/ims_pkg.sv]
// Shared constants, codes and structs of the Ising Metropolis sweep block.
`default_nettype none

package ims_pkg;

   // Lattice geometry: SIDE x SIDE spins with periodic wrap.
   localparam int SIDE   = 8;
   localparam int NSITES = SIDE * SIDE;
   localparam int ROW_W  = $clog2(SIDE);
   localparam int SUM_W  = $clog2(NSITES) + 2;

   // Field and register widths.
   localparam int RAND_W    = 32;
   localparam int THR_W     = 32;
   localparam int SWEEP_W   = 20;
   localparam int POS_OUT_W = 3;
   localparam int MAG_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [ROW_W-1:0] LAST_POS = ROW_W'(SIDE - 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_DE4  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_DE8  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURN_IN_SWEEPS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SWEEPS   = 2'd3;

   localparam logic [SWEEP_W-1:0] BURN_IN_RESET = 20'd500;
   localparam logic [SWEEP_W-1:0] TOTAL_RESET   = 20'd100000;

   // Word kinds on the request channel.
   localparam logic KIND_SITE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // Neighbors agreeing with the center spin; fewer than three always flips.
   localparam logic [2:0] AGREE_DE4 = 3'd3;
   localparam logic [2:0] AGREE_DE8 = 3'd4;

   // Access request to the lattice row store.
   typedef struct packed {
      logic             rd_a_en;
      logic [ROW_W-1:0] rd_a_addr;
      logic             rd_b_en;
      logic [ROW_W-1:0] rd_b_addr;
      logic             wr_en;
      logic [ROW_W-1:0] wr_addr;
      logic [SIDE-1:0]  wr_data;
      logic             clear;
   } mem_req_type;

   // Outcome of one site update.
   typedef struct packed {
      logic flip;
      logic spin_old;
      logic spin_new;
   } upd_type;

endpackage

`default_nettype wire

[hdl/ims_lattice.sv]
// Lattice row store: two registered read ports, one write port, row valid bits.
`default_nettype none

module ims_lattice (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ims_pkg::mem_req_type        mem_req,
   output logic [ims_pkg::SIDE-1:0]         rd_a_data,
   output logic [ims_pkg::SIDE-1:0]         rd_b_data
);

   logic [ims_pkg::SIDE-1:0] mem [ims_pkg::SIDE];
   logic [ims_pkg::SIDE-1:0] valid_ff;
   logic [ims_pkg::SIDE-1:0] valid_in;
   logic [ims_pkg::SIDE-1:0] rd_a_ff;
   logic [ims_pkg::SIDE-1:0] rd_b_ff;
   logic                     fwd_a;
   logic                     fwd_b;

   assign fwd_a = mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_a_addr);
   assign fwd_b = mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_b_addr);

   // A row that was never written since restart reads as all spins up.
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
      if (mem_req.clear) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_a_en) begin
         if (fwd_a) begin
            rd_a_ff <= mem_req.wr_data;
         end else if (!valid_ff[mem_req.rd_a_addr]) begin
            rd_a_ff <= '1;
         end else begin
            rd_a_ff <= mem[mem_req.rd_a_addr];
         end
      end
      if (mem_req.rd_b_en) begin
         if (fwd_b) begin
            rd_b_ff <= mem_req.wr_data;
         end else if (!valid_ff[mem_req.rd_b_addr]) begin
            rd_b_ff <= '1;
         end else begin
            rd_b_ff <= mem[mem_req.rd_b_addr];
         end
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      mem_req.clear |=> (valid_ff == '0))
      else $error("row valid bits not cleared on restart");

   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && !mem_req.clear) |=> valid_ff[$past(mem_req.wr_addr)])
      else $error("written row not marked valid");

   a_forward_a: assert property (@(posedge clock) disable iff (reset)
      (mem_req.rd_a_en && mem_req.wr_en && (mem_req.rd_a_addr == mem_req.wr_addr))
      |=> (rd_a_ff == $past(mem_req.wr_data)))
      else $error("read port A missed the row written in the same cycle");

endmodule

`default_nettype wire

[hdl/ims_update.sv]
// Metropolis decision for one site from its row and the rows above and below.
`default_nettype none

module ims_update (
   input  wire logic [ims_pkg::SIDE-1:0]   row_up,
   input  wire logic [ims_pkg::SIDE-1:0]   row_mid,
   input  wire logic [ims_pkg::SIDE-1:0]   row_dn,
   input  wire logic [ims_pkg::ROW_W-1:0]  col,
   input  wire logic [ims_pkg::RAND_W-1:0] rand_fraction,
   input  wire logic [ims_pkg::THR_W-1:0]  threshold_de4,
   input  wire logic [ims_pkg::THR_W-1:0]  threshold_de8,
   output ims_pkg::upd_type                upd,
   output logic [ims_pkg::SIDE-1:0]        row_new
);

   logic [ims_pkg::ROW_W-1:0] col_m;
   logic [ims_pkg::ROW_W-1:0] col_p;
   logic [2:0]                n_up;
   logic [2:0]                agree;
   logic                      spin;
   logic                      flip;

   assign col_m = (col == '0) ? ims_pkg::LAST_POS : col - 1'b1;
   assign col_p = (col == ims_pkg::LAST_POS) ? '0 : col + 1'b1;
   assign spin  = row_mid[col];

   assign n_up = 3'(row_up[col]) + 3'(row_dn[col]) + 3'(row_mid[col_m])
               + 3'(row_mid[col_p]);

   // The energy change is 2*(2*agree - 4), so it is zero or below when at most
   // two neighbors agree with the center spin.
   assign agree = spin ? n_up : 3'd4 - n_up;

   always_comb begin
      case (agree)
         ims_pkg::AGREE_DE4: flip = rand_fraction < threshold_de4;
         ims_pkg::AGREE_DE8: flip = rand_fraction < threshold_de8;
         default:            flip = 1'b1;
      endcase
   end

   always_comb begin
      row_new      = row_mid;
      row_new[col] = ~spin;
   end

   assign upd.flip     = flip;
   assign upd.spin_old = spin;
   assign upd.spin_new = flip ? ~spin : spin;

endmodule

`default_nettype wire

[hdl/ising_metropolis_sweep.sv]
// Ising Metropolis sweep: a square spin lattice updated site by site in row-major order.
// The request channel carries one word per site visit: kind selects a site update (0),
// which uses rand_fraction for the acceptance test, or a restart (1), which sets every
// spin up and returns to site (0,0) at sweep 0. Every request word yields exactly one
// response word with the visited site, its new spin, the flip mark, the magnetization
// after the step, and the sweep-end, sample and run-done marks.
// The spins live in a row-wide store with two read ports. An accepted word reads the rows
// above and below its site in the accept cycle and its own row in the next one; in the
// evaluate state it decides the flip, writes the row back on a flip and loads the response
// register. A new word is taken in the cycle the previous one retires, and not before;
// the pace is set by the row reads of each site on the row store. A row written in the
// cycle a read starts is forwarded. A stalled response holds the block in its decision
// state and the request side waits.
// Reset (synchronous) sets all spins up through the row valid bits, clears the site and
// sweep counters and loads the registers with their reset values; no clearing pass is
// needed. The user must write the csr registers only while the block is idle; the block
// does not enforce this. The csr channel is ready whenever reset is low; the request
// channel is not ready during reset either.
`default_nettype none

module ising_metropolis_sweep (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_kind,
   input  wire logic [ims_pkg::RAND_W-1:0]     req_rand_fraction,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [ims_pkg::POS_OUT_W-1:0]       rsp_row,
   output logic [ims_pkg::POS_OUT_W-1:0]       rsp_col,
   output logic                                rsp_spin_up,
   output logic                                rsp_flipped,
   output logic                                rsp_sweep_end,
   output logic signed [ims_pkg::MAG_W-1:0]    rsp_magnetization,
   output logic                                rsp_sample_valid,
   output logic                                rsp_run_done,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ims_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ims_pkg::CSR_DAT_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Configuration registers.
   logic [ims_pkg::THR_W-1:0]   th4_ff;
   logic [ims_pkg::THR_W-1:0]   th8_ff;
   logic [ims_pkg::SWEEP_W-1:0] burn_in_ff;
   logic [ims_pkg::SWEEP_W-1:0] total_ff;

   // Lattice position and statistics.
   logic [ims_pkg::ROW_W-1:0]   site_row_ff, site_row_in;
   logic [ims_pkg::ROW_W-1:0]   site_col_ff, site_col_in;
   logic [ims_pkg::SWEEP_W-1:0] sweep_ff, sweep_in;
   logic signed [ims_pkg::SUM_W-1:0] sum_ff, sum_in;

   // Word in flight.
   logic                        item_kind_ff;
   logic [ims_pkg::RAND_W-1:0]  item_rand_ff;
   logic [ims_pkg::SIDE-1:0]    row_up_ff;

   // Response register.
   logic                              rsp_valid_ff;
   logic [ims_pkg::POS_OUT_W-1:0]     rsp_row_ff;
   logic [ims_pkg::POS_OUT_W-1:0]     rsp_col_ff;
   logic                              rsp_spin_up_ff;
   logic                              rsp_flipped_ff;
   logic                              rsp_sweep_end_ff;
   logic signed [ims_pkg::MAG_W-1:0]  rsp_mag_ff;
   logic                              rsp_sample_valid_ff;
   logic                              rsp_run_done_ff;

   logic                        req_accept;
   logic                        restart;
   logic                        out_free;
   logic                        commit;
   logic                        active;
   logic                        flipped;
   logic                        col_last;
   logic                        row_last;
   logic                        wrap;
   logic [ims_pkg::ROW_W-1:0]   nxt_row;
   logic [ims_pkg::ROW_W-1:0]   nxt_col;
   logic [ims_pkg::SWEEP_W-1:0] nxt_sweep;
   logic signed [ims_pkg::SUM_W-1:0] nxt_sum;
   logic signed [ims_pkg::MAG_W-1:0] mag_sat;
   logic [ims_pkg::ROW_W-1:0]   rd_row_m;
   logic [ims_pkg::ROW_W-1:0]   rd_row_p;

   ims_pkg::mem_req_type        mem_req;
   ims_pkg::upd_type            upd;
   logic [ims_pkg::SIDE-1:0]    rd_a_data;
   logic [ims_pkg::SIDE-1:0]    rd_b_data;
   logic [ims_pkg::SIDE-1:0]    row_new;

   // Handshakes.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign commit     = (state_ff == ST_EVAL) && out_free;
   assign req_ready  = ((state_ff == ST_IDLE) || commit) && !reset;
   assign req_accept = req_valid && req_ready;
   assign restart    = req_accept && (req_kind == ims_pkg::KIND_RESTART);
   assign csr_ready  = !reset;

   // Decision for the word in flight; a restart word passes through inactive.
   ims_update u_update (
      .row_up        (row_up_ff),
      .row_mid       (rd_a_data),
      .row_dn        (rd_b_data),
      .col           (site_col_ff),
      .rand_fraction (item_rand_ff),
      .threshold_de4 (th4_ff),
      .threshold_de8 (th8_ff),
      .upd           (upd),
      .row_new       (row_new)
   );

   assign active   = (item_kind_ff == ims_pkg::KIND_SITE) && (sweep_ff < total_ff);
   assign flipped  = active && upd.flip;
   assign col_last = site_col_ff == ims_pkg::LAST_POS;
   assign row_last = site_row_ff == ims_pkg::LAST_POS;
   assign wrap     = active && col_last && row_last;

   always_comb begin
      nxt_col = site_col_ff;
      nxt_row = site_row_ff;
      if (active) begin
         nxt_col = col_last ? '0 : site_col_ff + 1'b1;
         if (col_last) begin
            nxt_row = row_last ? '0 : site_row_ff + 1'b1;
         end
      end
   end

   assign nxt_sweep = sweep_ff + ims_pkg::SWEEP_W'(wrap);

   always_comb begin
      nxt_sum = sum_ff;
      if (flipped) begin
         nxt_sum = upd.spin_old ? sum_ff - ims_pkg::SUM_W'(2)
                                : sum_ff + ims_pkg::SUM_W'(2);
      end
   end

   // Magnetization clamps to the signed 8-bit range on wide lattices.
   always_comb begin
      if (nxt_sum > 127) begin
         mag_sat = 8'sd127;
      end else if (nxt_sum < -128) begin
         mag_sat = -8'sd128;
      end else begin
         mag_sat = ims_pkg::MAG_W'(nxt_sum);
      end
   end

   // Counter updates: the retiring word advances, a newly accepted restart overrides.
   always_comb begin
      site_row_in = site_row_ff;
      site_col_in = site_col_ff;
      sweep_in    = sweep_ff;
      sum_in      = sum_ff;
      if (commit) begin
         site_row_in = nxt_row;
         site_col_in = nxt_col;
         sweep_in    = nxt_sweep;
         sum_in      = nxt_sum;
      end
      if (restart) begin
         site_row_in = '0;
         site_col_in = '0;
         sweep_in    = '0;
         sum_in      = ims_pkg::SUM_W'(ims_pkg::NSITES);
      end
   end

   // Rows above and below are read at accept from the position the word will see.
   assign rd_row_m = (site_row_in == '0) ? ims_pkg::LAST_POS : site_row_in - 1'b1;
   assign rd_row_p = (site_row_in == ims_pkg::LAST_POS) ? '0 : site_row_in + 1'b1;

   always_comb begin
      mem_req.rd_a_en   = req_accept || (state_ff == ST_READ);
      mem_req.rd_a_addr = (state_ff == ST_READ) ? site_row_ff : rd_row_m;
      mem_req.rd_b_en   = req_accept;
      mem_req.rd_b_addr = rd_row_p;
      mem_req.wr_en     = commit && flipped;
      mem_req.wr_addr   = site_row_ff;
      mem_req.wr_data   = row_new;
      mem_req.clear     = restart;
   end

   ims_lattice u_lattice (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (commit) begin
               state_in = req_accept ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (commit) begin
         rsp_row_ff          <= ims_pkg::POS_OUT_W'(site_row_ff);
         rsp_col_ff          <= ims_pkg::POS_OUT_W'(site_col_ff);
         rsp_spin_up_ff      <= active ? upd.spin_new : upd.spin_old;
         rsp_flipped_ff      <= flipped;
         rsp_sweep_end_ff    <= wrap;
         rsp_mag_ff          <= mag_sat;
         rsp_sample_valid_ff <= wrap && (sweep_ff > burn_in_ff);
         rsp_run_done_ff     <= nxt_sweep >= total_ff;
      end
   end

   // Word in flight; the row above is kept while port A fetches the site's own row.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_kind_ff <= req_kind;
         item_rand_ff <= req_rand_fraction;
      end
      if (state_ff == ST_READ) begin
         row_up_ff <= rd_a_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_row_ff <= '0;
         site_col_ff <= '0;
         sweep_ff    <= '0;
         sum_ff      <= ims_pkg::SUM_W'(ims_pkg::NSITES);
      end else begin
         site_row_ff <= site_row_in;
         site_col_ff <= site_col_in;
         sweep_ff    <= sweep_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         th4_ff     <= '0;
         th8_ff     <= '0;
         burn_in_ff <= ims_pkg::BURN_IN_RESET;
         total_ff   <= ims_pkg::TOTAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ims_pkg::CSR_THRESHOLD_DE4:  th4_ff     <= csr_wdata;
            ims_pkg::CSR_THRESHOLD_DE8:  th8_ff     <= csr_wdata;
            ims_pkg::CSR_BURN_IN_SWEEPS: burn_in_ff <= csr_wdata[ims_pkg::SWEEP_W-1:0];
            ims_pkg::CSR_TOTAL_SWEEPS:   total_ff   <= csr_wdata[ims_pkg::SWEEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_row           = rsp_row_ff;
   assign rsp_col           = rsp_col_ff;
   assign rsp_spin_up       = rsp_spin_up_ff;
   assign rsp_flipped       = rsp_flipped_ff;
   assign rsp_sweep_end     = rsp_sweep_end_ff;
   assign rsp_magnetization = rsp_mag_ff;
   assign rsp_sample_valid  = rsp_sample_valid_ff;
   assign rsp_run_done      = rsp_run_done_ff;

endmodule

`default_nettype wire

[dv/ising_metropolis_sweep_tb.sv]
`timescale 1ns / 100ps
// Testbench for the Ising Metropolis sweep block: lattice predictor, random drive and checks.

typedef struct packed {
   logic [2:0]        row;
   logic [2:0]        col;
   logic              spin_up;
   logic              flipped;
   logic              sweep_end;
   logic signed [7:0] magnetization;
   logic              sample_valid;
   logic              run_done;
} site_result_type;

class spin_lattice_checker;
   bit              spin_grid [ims_pkg::SIDE][ims_pkg::SIDE];
   int unsigned     site_row;
   int unsigned     site_col;
   int unsigned     sweep_count;
   int              spin_total;
   logic [31:0]     thr_de4;
   logic [31:0]     thr_de8;
   logic [19:0]     burn_in;
   logic [19:0]     sweep_limit;
   site_result_type expected_sites [$];
   int              mismatches;

   function new();
      thr_de4 = '0;
      thr_de8 = '0;
      burn_in = ims_pkg::BURN_IN_RESET;
      sweep_limit = ims_pkg::TOTAL_RESET;
      mismatches = 0;
      restart_lattice();
   endfunction

   function void restart_lattice();
      foreach (spin_grid[r, c]) spin_grid[r][c] = 1'b1;
      site_row = 0;
      site_col = 0;
      sweep_count = 0;
      spin_total = ims_pkg::NSITES;
   endfunction

   function int spin_value(int unsigned r, int unsigned c);
      return spin_grid[r][c] ? 1 : -1;
   endfunction

   function void write_register(logic [1:0] index, logic [31:0] data);
      case (index)
         ims_pkg::CSR_THRESHOLD_DE4: begin
            thr_de4 = data;
         end
         ims_pkg::CSR_THRESHOLD_DE8: begin
            thr_de8 = data;
         end
         ims_pkg::CSR_BURN_IN_SWEEPS: begin
            burn_in = data[19:0];
         end
         ims_pkg::CSR_TOTAL_SWEEPS: begin
            sweep_limit = data[19:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Visits one site the way the block does and returns the word it should send back.
   function site_result_type advance_lattice(logic kind, logic [31:0] fraction);
      site_result_type res;
      int unsigned     r;
      int unsigned     c;
      int unsigned     north;
      int unsigned     south;
      int unsigned     west;
      int unsigned     east;
      int              s;
      int              neighbors;
      int              delta_e;
      int              mag;
      logic            flip;
      if (kind == ims_pkg::KIND_RESTART) restart_lattice();
      r = site_row;
      c = site_col;
      res = '0;
      if (kind == ims_pkg::KIND_SITE && sweep_count < sweep_limit) begin
         north = (r + ims_pkg::SIDE - 1) % ims_pkg::SIDE;
         south = (r + 1) % ims_pkg::SIDE;
         west = (c + ims_pkg::SIDE - 1) % ims_pkg::SIDE;
         east = (c + 1) % ims_pkg::SIDE;
         s = spin_value(r, c);
         neighbors = spin_value(north, c) + spin_value(south, c) + spin_value(r, west)
                     + spin_value(r, east);
         delta_e = 2 * s * neighbors;
         if (delta_e <= 0) flip = 1'b1;
         else if (delta_e == 4) flip = fraction < thr_de4;
         else flip = fraction < thr_de8;
         if (flip) begin
            spin_grid[r][c] = ~spin_grid[r][c];
            spin_total -= 2 * s;
         end
         res.flipped = flip;
         if (c + 1 < ims_pkg::SIDE) begin
            site_col = c + 1;
         end else begin
            site_col = 0;
            if (r + 1 < ims_pkg::SIDE) begin
               site_row = r + 1;
            end else begin
               site_row = 0;
               res.sweep_end = 1'b1;
               res.sample_valid = sweep_count > burn_in;
               sweep_count++;
            end
         end
      end
      mag = spin_total;
      if (mag > 127) mag = 127;
      if (mag < -128) mag = -128;
      res.row = 3'(r);
      res.col = 3'(c);
      res.spin_up = spin_grid[r][c];
      res.magnetization = 8'(mag);
      res.run_done = sweep_count >= sweep_limit;
      return res;
   endfunction

   function void accept_word(logic kind, logic [31:0] fraction);
      expected_sites.insert(expected_sites.size(), advance_lattice(kind, fraction));
   endfunction

   function void check_word(site_result_type got);
      site_result_type want;
      if (expected_sites.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: result word with no request pending: row %0d col %0d",
                     $realtime, got.row, got.col);
         mismatches++;
         return;
      end
      want = expected_sites.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.spin_up !== want.spin_up
          || got.flipped !== want.flipped || got.sweep_end !== want.sweep_end
          || got.magnetization !== want.magnetization
          || got.sample_valid !== want.sample_valid || got.run_done !== want.run_done) begin
         if (mismatches < 10) begin
            $display("%0t: expected row %0d col %0d spin %b flip %b end %b mag %0d smp %b done %b",
                     $realtime, want.row, want.col, want.spin_up, want.flipped, want.sweep_end,
                     want.magnetization, want.sample_valid, want.run_done);
            $display("%0t: actual   row %0d col %0d spin %b flip %b end %b mag %0d smp %b done %b",
                     $realtime, got.row, got.col, got.spin_up, got.flipped, got.sweep_end,
                     got.magnetization, got.sample_valid, got.run_done);
         end
         mismatches++;
      end
   endfunction

   function int pending();
      return expected_sites.size();
   endfunction
endclass

module ising_metropolis_sweep_tb;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_WORDS = 150;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic                               req_kind;
   logic [ims_pkg::RAND_W-1:0]         req_rand_fraction;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [ims_pkg::POS_OUT_W-1:0]      rsp_row;
   logic [ims_pkg::POS_OUT_W-1:0]      rsp_col;
   logic                               rsp_spin_up;
   logic                               rsp_flipped;
   logic                               rsp_sweep_end;
   logic signed [ims_pkg::MAG_W-1:0]   rsp_magnetization;
   logic                               rsp_sample_valid;
   logic                               rsp_run_done;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [ims_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [ims_pkg::CSR_DAT_W-1:0]      csr_wdata;

   spin_lattice_checker lattice;
   int unsigned         cycle_count = 0;
   bit                  quiet = 1'b0;
   site_result_type     seen_word;

   ising_metropolis_sweep u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_rand_fraction (req_rand_fraction),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_row           (rsp_row),
      .rsp_col           (rsp_col),
      .rsp_spin_up       (rsp_spin_up),
      .rsp_flipped       (rsp_flipped),
      .rsp_sweep_end     (rsp_sweep_end),
      .rsp_magnetization (rsp_magnetization),
      .rsp_sample_valid  (rsp_sample_valid),
      .rsp_run_done      (rsp_run_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("ising_metropolis_sweep_tb: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word = {rsp_row, rsp_col, rsp_spin_up, rsp_flipped, rsp_sweep_end,
                      rsp_magnetization, rsp_sample_valid, rsp_run_done};
         lattice.check_word(seen_word);
      end
   end

   // Receiver stalls come in bursts of random length.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_word(logic kind, logic [31:0] fraction);
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_rand_fraction <= fraction;
      do @(posedge clock); while (!req_ready);
      lattice.accept_word(kind, fraction);
   endtask

   task automatic maybe_pause();
      if (!quiet && $urandom_range(3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(10)) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lattice.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_register(logic [ims_pkg::CSR_IDX_W-1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      lattice.write_register(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_threshold();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2, 3: return 32'h0400_0000 + $urandom_range(32'h3FFF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   // Sweep counts land in the low 20 bits; the upper bits carry noise the block must drop.
   function automatic logic [31:0] pick_sweeps(bit for_limit);
      logic [31:0] noise;
      logic [19:0] count;
      noise = $urandom;
      case ($urandom_range(7))
         0: count = for_limit ? 20'd0 : 20'hFFFFF;
         1: count = 20'hFFFFF;
         2: count = noise[19:0];
         3, 4: count = 20'd0;
         default: count = 20'($urandom_range(1, 3));
      endcase
      return {noise[31:20], count};
   endfunction

   // Random fractions lean on the threshold edges, where "below" decides the flip.
   function automatic logic [31:0] pick_fraction();
      case ($urandom_range(11))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return lattice.thr_de4;
         3: return lattice.thr_de4 - 1;
         4: return lattice.thr_de8;
         5: return lattice.thr_de8 - 1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic word_kind;
      int   phase;
      int   words;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = ims_pkg::KIND_SITE;
      req_rand_fraction = '0;
      csr_valid = 1'b0;
      csr_index = ims_pkg::CSR_THRESHOLD_DE4;
      csr_wdata = '0;
      lattice = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults: zero thresholds never accept an energy rise.
      send_word(ims_pkg::KIND_SITE, 32'h0);
      send_word(ims_pkg::KIND_SITE, 32'hFFFF_FFFF);
      send_word(ims_pkg::KIND_RESTART, 32'h8000_0000);
      drain_results();

      // Full thresholds: row 0 flips site by site, ending on a zero energy change; then an
      // equal fraction fails the strict compare and one just below it passes.
      program_register(ims_pkg::CSR_THRESHOLD_DE4, 32'hFFFF_FFFF);
      program_register(ims_pkg::CSR_THRESHOLD_DE8, 32'hFFFF_FFFF);
      program_register(ims_pkg::CSR_BURN_IN_SWEEPS, 32'hFFF0_0000);
      program_register(ims_pkg::CSR_TOTAL_SWEEPS, 32'hFFFF_FFFF);
      repeat (8) send_word(ims_pkg::KIND_SITE, 32'h0);
      send_word(ims_pkg::KIND_SITE, 32'hFFFF_FFFF);
      send_word(ims_pkg::KIND_SITE, 32'hFFFF_FFFE);
      drain_results();

      // A sweep limit of zero means the run is over at once, even after a restart.
      program_register(ims_pkg::CSR_THRESHOLD_DE4, 32'h0);
      program_register(ims_pkg::CSR_THRESHOLD_DE8, 32'h0);
      program_register(ims_pkg::CSR_TOTAL_SWEEPS, 32'h0);
      send_word(ims_pkg::KIND_SITE, 32'h0);
      send_word(ims_pkg::KIND_SITE, 32'hFFFF_FFFF);
      send_word(ims_pkg::KIND_RESTART, 32'h0);
      send_word(ims_pkg::KIND_SITE, 32'h0);
      drain_results();

      // Near-critical temperature, short run, no burn-in.
      program_register(ims_pkg::CSR_THRESHOLD_DE4, 32'h2C00_0000);
      program_register(ims_pkg::CSR_THRESHOLD_DE8, 32'h0790_0000);
      program_register(ims_pkg::CSR_BURN_IN_SWEEPS, 32'h0);
      program_register(ims_pkg::CSR_TOTAL_SWEEPS, 32'h3);

      for (phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            drain_results();
            program_register(ims_pkg::CSR_THRESHOLD_DE4, pick_threshold());
            program_register(ims_pkg::CSR_THRESHOLD_DE8, pick_threshold());
            program_register(ims_pkg::CSR_BURN_IN_SWEEPS, pick_sweeps(1'b0));
            program_register(ims_pkg::CSR_TOTAL_SWEEPS, pick_sweeps(1'b1));
         end
         quiet = (phase >= 4);
         for (words = 0; words < PHASE_WORDS; words++) begin
            if (phase == 1 && words == PHASE_WORDS / 2) drain_results();
            maybe_pause();
            word_kind = ((phase == 0 && words == 0) || $urandom_range(99) == 0) ?
                        ims_pkg::KIND_RESTART : ims_pkg::KIND_SITE;
            send_word(word_kind, pick_fraction());
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (lattice.mismatches == 0 && lattice.pending() == 0) begin
         $display("ising_metropolis_sweep_tb: PASS");
      end else begin
         $display("ising_metropolis_sweep_tb: FAIL");
      end
      $finish;
   end
endmodule

[sim.f]
hdl/ims_pkg.sv
hdl/ims_lattice.sv
hdl/ims_update.sv
hdl/ising_metropolis_sweep.sv
dv/ising_metropolis_sweep_tb.sv
